### rtl/vd_pkg.sv
// Shared types and constants of the K=3 rate-1/2 Viterbi decoder.
package vd_pkg;

   localparam int SAMPLE_W    = 8;   // received soft sample width
   localparam int BM_W        = 10;  // branch metric, signed
   localparam int PM_W        = 16;  // stored path metric, unsigned
   localparam int NM_W        = 18;  // path metric sum before normalization, signed
   localparam int START_STEPS = 2;   // trellis steps with only states 0 and 2 as origin
   localparam int TAIL_BITS   = 2;   // zero tail bits dropped on a flush
   localparam int RSP_W       = 8;   // result tdata width

   localparam logic [PM_W-1:0] PM_MAX = '1;

   // Branch metric index per target state, for the lower and upper predecessor
   localparam logic [1:0] BM_LOWER [4] = '{2'd0, 2'd2, 2'd3, 2'd1};
   localparam logic [1:0] BM_UPPER [4] = '{2'd3, 2'd1, 2'd0, 2'd2};

   typedef enum logic {
      MODE_HARD = 1'b0,
      MODE_SOFT = 1'b1
   } mode_type;

   typedef struct packed {
      logic acs;         // item accepted: add-compare-select, store decisions
      logic norm;        // normalize metrics, decide on traceback
      logic tb_prime;    // first survivor read in flight
      logic tb_step;     // one traceback step
      logic emit_shift;  // result beat taken
   } vd_cmd_type;

   typedef struct packed {
      logic start_tb;    // traceback due after this item
      logic tb_last;     // final traceback step
      logic emit_last;   // final result of the run
   } vd_status_type;

endpackage

### rtl/viterbi_decoder_k3_rate_half.sv
// Top level of the four-state Viterbi decoder for the K=3 rate-1/2 (7,5) code.
//
// req channel: one beat per trellis step, carrying two signed received samples
//   (positive means a one). req_tlast marks the final step of a zero-terminated
//   block: the decoder traces back from state 0, sends every decoded bit but
//   the two tail bits, and starts over.
// rsp channel: one decoded bit per beat, oldest first; rsp_tlast closes a run.
//   Once DECODE_LEN + TRACEBACK_DEPTH steps are held, a traceback from the best
//   state sends the oldest DECODE_LEN bits and keeps TRACEBACK_DEPTH steps.
// csr channel: writes decision_mode (0 hard, 1 soft); always ready; write it
//   only while the decoder is idle.
// Sequence: each accepted step is followed by a normalize state. A step that
//   starts a traceback over H held steps then primes the survivor read, walks
//   H traceback steps and sends its result beats; the traceback walks the
//   survivor store one entry per cycle through its single read port.
// req_tready is low from acceptance until normalize ends or the last result beat
//   is taken; a stalled rsp_tready holds the current beat and the whole decoder.
// Reset clears metrics and history and sets soft mode; req_tready is registered
//   and rises in the cycle after reset falls.
module viterbi_decoder_k3_rate_half
   import vd_pkg::*;
#(
   parameter int DECODE_LEN      = 32,
   parameter int TRACEBACK_DEPTH = 15
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [15:0]      req_tdata,   // [7:0] rx_first, [15:8] rx_second
   input  logic             req_tlast,   // flush
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // [0] decoded_bit, [7:1] zero
   output logic             rsp_tlast,   // last_of_run
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_data     // decision_mode
);

   vd_cmd_type    cmd;
   vd_status_type status;
   logic          decoded_bit;

   assign csr_ready = 1'b1;

   vd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid)
   );

   vd_datapath #(
      .DECODE_LEN      (DECODE_LEN),
      .TRACEBACK_DEPTH (TRACEBACK_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_wr      (csr_valid && csr_ready),
      .csr_data    (csr_data),
      .rx_first    ($signed(req_tdata[7:0])),
      .rx_second   ($signed(req_tdata[15:8])),
      .flush       (req_tlast),
      .decoded_bit (decoded_bit)
   );

   // zero-pad the decoded bit to a whole byte
   assign rsp_tdata = {{(RSP_W-1){1'b0}}, decoded_bit};
   assign rsp_tlast = status.emit_last;

endmodule

### rtl/vd_ctrl.sv
// Sequencing state machine of the Viterbi decoder.
module vd_ctrl
   import vd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          rsp_tready,
   input  vd_status_type status,
   output vd_cmd_type    cmd,
   output logic          req_tready,
   output logic          rsp_tvalid
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NORM,
      ST_TB_PRIME,
      ST_TB_RUN,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;
   logic      valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && ready_ff) begin
               cmd.acs  = 1'b1;
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            cmd.norm = 1'b1;
            state_in = status.start_tb ? ST_TB_PRIME : ST_IDLE;
         end
         ST_TB_PRIME: begin
            cmd.tb_prime = 1'b1;
            state_in     = ST_TB_RUN;
         end
         ST_TB_RUN: begin
            cmd.tb_step = 1'b1;
            if (status.tb_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_tready && valid_ff) begin
               cmd.emit_shift = 1'b1;
               if (status.emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == ST_IDLE);
         valid_ff <= (state_in == ST_EMIT);
      end
   end

   assign req_tready = ready_ff;
   assign rsp_tvalid = valid_ff;

endmodule

### rtl/vd_datapath.sv
// Metrics, survivor store, traceback and result shifter of the Viterbi decoder.
module vd_datapath
   import vd_pkg::*;
#(
   parameter int DECODE_LEN      = 32,
   parameter int TRACEBACK_DEPTH = 15
) (
   input  logic                       clock,
   input  logic                       reset,
   input  vd_cmd_type                 cmd,
   output vd_status_type              status,
   input  logic                       csr_wr,
   input  logic                       csr_data,
   input  logic signed [SAMPLE_W-1:0] rx_first,
   input  logic signed [SAMPLE_W-1:0] rx_second,
   input  logic                       flush,
   output logic                       decoded_bit
);

   localparam int STORE_DEPTH = DECODE_LEN + TRACEBACK_DEPTH;
   localparam int AW          = $clog2(STORE_DEPTH);
   localparam int CW          = $clog2(STORE_DEPTH + 1);

   localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(STORE_DEPTH);
   localparam logic [CW-1:0] KEEP_CNT  = CW'(TRACEBACK_DEPTH);
   localparam logic [CW-1:0] RUN_CNT   = CW'(DECODE_LEN);
   localparam logic [CW-1:0] TAIL_CNT  = CW'(TAIL_BITS);
   localparam logic [CW-1:0] ONE_CNT   = CW'(1);

   mode_type                mode_ff;
   logic [PM_W-1:0]         pm_ff [4];
   logic signed [NM_W-1:0]  nm_ff [4];
   logic                    flush_ff;
   logic [AW-1:0]           wp_ff;
   logic [CW-1:0]           steps_ff;
   logic [1:0]              phase_ff;

   logic [3:0]              store [STORE_DEPTH];
   logic [3:0]              rd_data_ff;
   logic [AW-1:0]           tb_ptr_ff;
   logic [CW-1:0]           tb_cnt_ff;
   logic [1:0]              cs_ff;
   logic [STORE_DEPTH-1:0]  sr_ff;
   logic [CW-1:0]           emit_cnt_ff;

   logic signed [BM_W-1:0]  bm [4];
   logic signed [NM_W-1:0]  acs_nm [4];
   logic [3:0]              acs_dec;
   logic signed [NM_W-1:0]  lo;
   logic [PM_W-1:0]         norm_pm [4];
   logic [1:0]              best;
   logic [AW-1:0]           newest;
   logic [AW-1:0]           tb_ptr_dec;
   logic [AW-1:0]           wp_inc;

   // Branch metrics for the four code word hypotheses
   always_comb begin
      logic signed [BM_W-1:0] y0;
      logic signed [BM_W-1:0] y1;
      logic signed [BM_W-1:0] t0;
      logic signed [BM_W-1:0] t1;
      logic [1:0]             sv;
      logic [1:0]             hd;
      y0 = BM_W'(rx_first);
      y1 = BM_W'(rx_second);
      for (int s = 0; s < 4; s++) begin
         sv = 2'(s);
         hd = 2'(~rx_first[SAMPLE_W-1] ^ sv[1]) + 2'(~rx_second[SAMPLE_W-1] ^ sv[0]);
         t0 = sv[1] ? -y0 : y0;
         t1 = sv[0] ? -y1 : y1;
         if (mode_ff == MODE_HARD) begin
            bm[s] = BM_W'(hd);
         end else begin
            bm[s] = t0 + t1;
         end
      end
   end

   // Add-compare-select; ties take the upper predecessor; start steps take the lower
   always_comb begin
      logic signed [NM_W-1:0] a;
      logic signed [NM_W-1:0] b;
      logic [1:0]             base;
      for (int s = 0; s < 4; s++) begin
         base = {s[0], 1'b0};
         a = $signed({{(NM_W-PM_W){1'b0}}, pm_ff[base]}) + NM_W'(bm[BM_LOWER[s]]);
         b = $signed({{(NM_W-PM_W){1'b0}}, pm_ff[base + 2'd1]}) + NM_W'(bm[BM_UPPER[s]]);
         if (phase_ff != 2'd0) begin
            acs_nm[s]  = a;
            acs_dec[s] = 1'b0;
         end else if (a < b) begin
            acs_nm[s]  = a;
            acs_dec[s] = 1'b0;
         end else begin
            acs_nm[s]  = b;
            acs_dec[s] = 1'b1;
         end
      end
   end

   // Normalization and best-state pick from the registered sums
   always_comb begin
      logic signed [NM_W-1:0] m01;
      logic signed [NM_W-1:0] m23;
      logic signed [NM_W-1:0] diff;
      logic [1:0]             t1;
      logic [1:0]             t2;
      m01 = (nm_ff[1] < nm_ff[0]) ? nm_ff[1] : nm_ff[0];
      m23 = (nm_ff[3] < nm_ff[2]) ? nm_ff[3] : nm_ff[2];
      lo  = (m23 < m01) ? m23 : m01;
      for (int s = 0; s < 4; s++) begin
         diff = nm_ff[s] - lo;
         norm_pm[s] = (diff[NM_W-1:PM_W] != '0) ? PM_MAX : diff[PM_W-1:0];
      end
      t1   = (nm_ff[0] < nm_ff[1]) ? 2'd0 : 2'd1;
      t2   = (nm_ff[2] < nm_ff[3]) ? 2'd2 : 2'd3;
      best = (nm_ff[t1] < nm_ff[t2]) ? t1 : t2;
   end

   assign newest     = (wp_ff == '0) ? LAST_ADDR : wp_ff - AW'(1);
   assign tb_ptr_dec = (tb_ptr_ff == '0) ? LAST_ADDR : tb_ptr_ff - AW'(1);
   assign wp_inc     = (wp_ff == LAST_ADDR) ? '0 : wp_ff + AW'(1);

   assign status.start_tb  = flush_ff ? (steps_ff > TAIL_CNT) : (steps_ff == FULL_CNT);
   assign status.tb_last   = (tb_cnt_ff == ONE_CNT);
   assign status.emit_last = (emit_cnt_ff == ONE_CNT);
   assign decoded_bit      = sr_ff[0];

   // Control state: mode, metrics, store position, fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_SOFT;
         wp_ff       <= '0;
         steps_ff    <= '0;
         phase_ff    <= 2'(START_STEPS);
         emit_cnt_ff <= '0;
         for (int s = 0; s < 4; s++) begin
            pm_ff[s] <= '0;
         end
      end else begin
         if (csr_wr) begin
            mode_ff <= mode_type'(csr_data);
         end
         if (cmd.acs) begin
            wp_ff <= wp_inc;
            if (steps_ff != FULL_CNT) begin
               steps_ff <= steps_ff + ONE_CNT;
            end
            if (phase_ff != 2'd0) begin
               phase_ff <= phase_ff - 2'd1;
            end
         end
         if (cmd.norm) begin
            if (flush_ff) begin
               // drop all history, start a new block
               wp_ff       <= '0;
               steps_ff    <= '0;
               phase_ff    <= 2'(START_STEPS);
               emit_cnt_ff <= steps_ff - TAIL_CNT;
               for (int s = 0; s < 4; s++) begin
                  pm_ff[s] <= '0;
               end
            end else begin
               for (int s = 0; s < 4; s++) begin
                  pm_ff[s] <= norm_pm[s];
               end
               if (steps_ff == FULL_CNT) begin
                  steps_ff    <= KEEP_CNT;
                  emit_cnt_ff <= RUN_CNT;
               end
            end
         end
         if (cmd.emit_shift) begin
            emit_cnt_ff <= emit_cnt_ff - ONE_CNT;
         end
      end
   end

   // Payload: sums, traceback walk, decoded bit shifter
   always_ff @(posedge clock) begin
      if (cmd.acs) begin
         flush_ff <= flush;
         for (int s = 0; s < 4; s++) begin
            nm_ff[s] <= acs_nm[s];
         end
      end
      if (cmd.norm) begin
         tb_ptr_ff <= newest;
         tb_cnt_ff <= steps_ff;
         cs_ff     <= flush_ff ? 2'd0 : best;
      end
      if (cmd.tb_prime) begin
         tb_ptr_ff <= tb_ptr_dec;
      end
      if (cmd.tb_step) begin
         tb_ptr_ff <= tb_ptr_dec;
         tb_cnt_ff <= tb_cnt_ff - ONE_CNT;
         sr_ff     <= {sr_ff[STORE_DEPTH-2:0], cs_ff[1]};
         cs_ff     <= {cs_ff[0], rd_data_ff[cs_ff]};
      end
      if (cmd.emit_shift) begin
         sr_ff <= {1'b0, sr_ff[STORE_DEPTH-1:1]};
      end
   end

   // Survivor store: one decision nibble per trellis step
   always_ff @(posedge clock) begin
      if (cmd.acs) begin
         store[wp_ff] <= acs_dec;
      end
      rd_data_ff <= store[tb_ptr_ff];
   end

endmodule

### rtl/vd_checker.sv
// Port-level checks of the Viterbi decoder, bound to its top level.
module vd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // one item at a time: no intake while results are pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while results pending");

   // an accepted item closes the input for the next cycle
   a_accept_closes: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input still ready after accept");

   // padding bits of the result stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:1] == 7'd0)
      else $error("result padding not zero");

   // reset closes both channels
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("channel active after reset");

endmodule

bind viterbi_decoder_k3_rate_half vd_checker u_vd_checker (.*);
